>>> rtl/core/gers_pkg.sv
`default_nettype none

package gers_pkg;

  localparam int COORD_WIDTH_DEF = 24;

  localparam int COEF_BITS = 16;
  localparam int COEF_HALF = 32768;
  localparam logic [16:0] COEF_ONE = 17'd65536;

  localparam int BOB_W  = 17;
  localparam int DAMP_W = 16;
  localparam int JUMP_W = 19;
  localparam int CNT_W  = 32;
  localparam int MJSQ_W = 2 * JUMP_W;

  localparam logic [BOB_W-1:0]  BOB_MAX   = 17'd65536;
  localparam logic [BOB_W-1:0]  BOB_RST   = 17'd16384;
  localparam logic [DAMP_W-1:0] DAMP_MAX  = 16'd64880;
  localparam logic [DAMP_W-1:0] DAMP_RST  = 16'd55706;
  localparam logic [JUMP_W-1:0] JUMP_MIN  = 19'd3277;
  localparam logic [JUMP_W-1:0] JUMP_MAX  = 19'd327680;
  localparam logic [JUMP_W-1:0] JUMP_RST  = 19'd32768;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_BOB  = 2'd0;
  localparam logic [1:0] REG_DAMP = 2'd1;
  localparam logic [1:0] REG_JUMP = 2'd2;

  typedef struct packed {
    logic load;
    logic seed;
    logic sq;
    logic mrg;
    logic bob;
    logic fin;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/gers_in_if.sv
`default_nettype none

interface gers_in_if #(
  parameter int COORD_WIDTH = gers_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] raw_x;
  logic signed [COORD_WIDTH-1:0] raw_y;
  logic signed [COORD_WIDTH-1:0] raw_z;
  logic                          restart;

  modport source (output valid, output raw_x, output raw_y, output raw_z, output restart,
                  input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z, input restart,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/gers_out_if.sv
`default_nettype none

interface gers_out_if #(
  parameter int COORD_WIDTH = gers_pkg::COORD_WIDTH_DEF
) ();
  logic                             valid;
  logic                             ready;
  logic signed [COORD_WIDTH-1:0]    out_x;
  logic signed [COORD_WIDTH-1:0]    out_y;
  logic signed [COORD_WIDTH-1:0]    out_z;
  logic                             refused;
  logic [gers_pkg::CNT_W-1:0]       refused_total;

  modport source (output valid, output out_x, output out_y, output out_z, output refused,
                  output refused_total, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z, input refused,
                input refused_total, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gers_lane.sv
`default_nettype none

module gers_lane #(
  parameter int COORD_WIDTH = gers_pkg::COORD_WIDTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire gers_pkg::ctl_t                ctl_i,
  input  wire                                refuse_i,
  input  wire logic signed [COORD_WIDTH-1:0] raw_i,
  input  wire [gers_pkg::BOB_W-1:0]          weight_i,
  input  wire [gers_pkg::BOB_W-1:0]          bob_i,
  input  wire [gers_pkg::JUMP_W-1:0]         jump_i,
  output logic [2*COORD_WIDTH-1:0]           sq_o,
  output logic                               big_o,
  output logic signed [COORD_WIDTH-1:0]      res_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = CW + 19;
  localparam int CMPW = (CW > gers_pkg::JUMP_W) ? CW : gers_pkg::JUMP_W;

  logic signed [CW-1:0] mean_q, raw_q, m0_q, m_q;
  logic signed [CW-1:0] m0_d, m_d;
  logic signed [DW-1:0] d_q, d_d, r_d, r_q, m_full, o_full;
  logic [CW-1:0]        abs_q, abs_d;
  logic [2*CW-1:0]      sq_q;
  logic signed [PW-1:0] pw_q, pb_q, pw_rnd, pb_rnd, pw_sh, pb_sh;
  logic                 big_q;

  assign m0_d  = ctl_i.seed ? raw_i : mean_q;
  assign d_d   = {raw_i[CW-1], raw_i} - {m0_d[CW-1], m0_d};
  assign abs_d = d_d[DW-1] ? CW'(-d_d) : d_d[CW-1:0];

  // round to nearest, ties up: floor((p + half) / 2^16)
  assign pw_rnd = pw_q + $signed(PW'(gers_pkg::COEF_HALF));
  assign pw_sh  = pw_rnd >>> gers_pkg::COEF_BITS;
  assign m_full = {m0_q[CW-1], m0_q} + pw_sh[DW-1:0];
  assign m_d    = m_full[CW-1:0];
  assign r_d    = {raw_q[CW-1], raw_q} - {m_d[CW-1], m_d};

  assign pb_rnd = pb_q + $signed(PW'(gers_pkg::COEF_HALF));
  assign pb_sh  = pb_rnd >>> gers_pkg::COEF_BITS;
  assign o_full = {m_q[CW-1], m_q} + pb_sh[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
    end else if (ctl_i.fin) begin
      mean_q <= refuse_i ? m0_q : m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      raw_q <= raw_i;
      m0_q  <= m0_d;
      d_q   <= d_d;
      abs_q <= abs_d;
    end
    if (ctl_i.sq) begin
      sq_q  <= abs_q * abs_q;
      pw_q  <= $signed({1'b0, weight_i}) * d_q;
      big_q <= CMPW'(abs_q) > CMPW'(jump_i);
    end
    if (ctl_i.mrg) begin
      m_q <= m_d;
      r_q <= r_d;
    end
    if (ctl_i.bob) begin
      pb_q <= $signed({1'b0, bob_i}) * r_q;
    end
  end

  assign sq_o  = sq_q;
  assign big_o = big_q;
  assign res_o = refuse_i ? m0_q : o_full[CW-1:0];

endmodule

`default_nettype wire

>>> rtl/core/gers_merge.sv
`default_nettype none

module gers_merge #(
  parameter int COORD_WIDTH = gers_pkg::COORD_WIDTH_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire gers_pkg::ctl_t              ctl_i,
  input  wire [2*COORD_WIDTH-1:0]          sq_x_i,
  input  wire [2*COORD_WIDTH-1:0]          sq_y_i,
  input  wire [2*COORD_WIDTH-1:0]          sq_z_i,
  input  wire [2:0]                        big_i,
  input  wire [gers_pkg::MJSQ_W-1:0]       jump_sq_i,
  output logic                             refuse_o,
  output logic [gers_pkg::CNT_W-1:0]       count_o
);

  localparam int SW = (2*COORD_WIDTH + 2 > gers_pkg::MJSQ_W) ?
                      2*COORD_WIDTH + 2 : gers_pkg::MJSQ_W;

  logic [SW-1:0]              dist_d;
  logic                       refuse_q;
  logic [gers_pkg::CNT_W-1:0] count_q;

  assign dist_d = SW'(sq_x_i) + SW'(sq_y_i) + SW'(sq_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refuse_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (ctl_i.mrg) begin
        refuse_q <= (|big_i) || (dist_d > SW'(jump_sq_i));
      end
      // saturating refusal count
      if (ctl_i.bob && refuse_q && !(&count_q)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign refuse_o = refuse_q;
  assign count_o  = count_q;

endmodule

`default_nettype wire

>>> rtl/core/gated_ema_residual_scaler_3d_top.sv
// one accepted word at a time steps through square, merge, residual multiply and final
// round, which loads the output register once it is free; the shared control sequence
//   (seed/diff, square, merge, residual multiply, final round) walks all three lanes
//   together; a new word is taken while the previous result still waits on the output
// reset: async active low, clears mean, mean-valid, refusal count and control state;
//   registers return to bob_scale 16384, damping 55706, max_jump 32768
`default_nettype none

module gated_ema_residual_scaler_3d_top #(
  parameter int COORD_WIDTH = gers_pkg::COORD_WIDTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  gers_in_if.sink                             sample_i,
  gers_out_if.source                          result_o,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [gers_pkg::PADDR_W-1:0]         paddr,
  input  wire [gers_pkg::PDATA_W-1:0]         pwdata,
  output logic [gers_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int CW = COORD_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_MRG  = 3'd2;
  localparam logic [2:0] S_BOB  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [gers_pkg::BOB_W-1:0]  bob_q;
  logic [gers_pkg::DAMP_W-1:0] damp_q;
  logic [gers_pkg::JUMP_W-1:0] jump_q;
  logic [gers_pkg::MJSQ_W-1:0] jump_sq_q;
  logic [gers_pkg::BOB_W-1:0]  weight_q;
  logic                        wr_en;

  logic                        mean_valid_q;
  logic                        accept, load_out;
  gers_pkg::ctl_t              ctl;

  logic [2*CW-1:0]             sq_x, sq_y, sq_z;
  logic [2:0]                  big;
  logic                        refuse;
  logic [gers_pkg::CNT_W-1:0]  count;
  logic signed [CW-1:0]        res_x, res_y, res_z;

  logic                        out_valid_q;
  logic signed [CW-1:0]        out_x_q, out_y_q, out_z_q;
  logic                        refused_q;
  logic [gers_pkg::CNT_W-1:0]  total_q;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bob_q  <= gers_pkg::BOB_RST;
      damp_q <= gers_pkg::DAMP_RST;
      jump_q <= gers_pkg::JUMP_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        gers_pkg::REG_BOB: begin
          bob_q <= (pwdata[gers_pkg::BOB_W-1:0] > gers_pkg::BOB_MAX) ?
                   gers_pkg::BOB_MAX : pwdata[gers_pkg::BOB_W-1:0];
        end
        gers_pkg::REG_DAMP: begin
          damp_q <= (pwdata[gers_pkg::DAMP_W-1:0] > gers_pkg::DAMP_MAX) ?
                    gers_pkg::DAMP_MAX : pwdata[gers_pkg::DAMP_W-1:0];
        end
        gers_pkg::REG_JUMP: begin
          if (pwdata[gers_pkg::JUMP_W-1:0] < gers_pkg::JUMP_MIN) begin
            jump_q <= gers_pkg::JUMP_MIN;
          end else if (pwdata[gers_pkg::JUMP_W-1:0] > gers_pkg::JUMP_MAX) begin
            jump_q <= gers_pkg::JUMP_MAX;
          end else begin
            jump_q <= pwdata[gers_pkg::JUMP_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gers_pkg::REG_BOB:  prdata = gers_pkg::PDATA_W'(bob_q);
      gers_pkg::REG_DAMP: prdata = gers_pkg::PDATA_W'(damp_q);
      gers_pkg::REG_JUMP: prdata = gers_pkg::PDATA_W'(jump_q);
      default:            prdata = '0;
    endcase
  end

  // derived coefficients, refreshed every cycle
  always_ff @(posedge clk_i) begin
    jump_sq_q <= jump_q * jump_q;
    weight_q  <= gers_pkg::COEF_ONE - gers_pkg::BOB_W'(damp_q);
  end

  // sequencer
  assign sample_i.ready = (state_q == S_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;
  assign load_out       = (state_q == S_FIN) && (!out_valid_q || result_o.ready);

  assign ctl.load = accept;
  assign ctl.seed = sample_i.restart || !mean_valid_q;
  assign ctl.sq   = (state_q == S_SQ);
  assign ctl.mrg  = (state_q == S_MRG);
  assign ctl.bob  = (state_q == S_BOB);
  assign ctl.fin  = load_out;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_SQ;
      S_SQ:    state_d = S_MRG;
      S_MRG:   state_d = S_BOB;
      S_BOB:   state_d = S_FIN;
      S_FIN:   if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mean_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        mean_valid_q <= 1'b1;
      end
    end
  end

  gers_lane #(.COORD_WIDTH(CW)) u_lane_x (
    .clk_i, .rst_ni, .ctl_i(ctl), .refuse_i(refuse), .raw_i(sample_i.raw_x),
    .weight_i(weight_q), .bob_i(bob_q), .jump_i(jump_q),
    .sq_o(sq_x), .big_o(big[0]), .res_o(res_x)
  );

  gers_lane #(.COORD_WIDTH(CW)) u_lane_y (
    .clk_i, .rst_ni, .ctl_i(ctl), .refuse_i(refuse), .raw_i(sample_i.raw_y),
    .weight_i(weight_q), .bob_i(bob_q), .jump_i(jump_q),
    .sq_o(sq_y), .big_o(big[1]), .res_o(res_y)
  );

  gers_lane #(.COORD_WIDTH(CW)) u_lane_z (
    .clk_i, .rst_ni, .ctl_i(ctl), .refuse_i(refuse), .raw_i(sample_i.raw_z),
    .weight_i(weight_q), .bob_i(bob_q), .jump_i(jump_q),
    .sq_o(sq_z), .big_o(big[2]), .res_o(res_z)
  );

  gers_merge #(.COORD_WIDTH(CW)) u_merge (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .sq_x_i(sq_x), .sq_y_i(sq_y), .sq_z_i(sq_z), .big_i(big),
    .jump_sq_i(jump_sq_q), .refuse_o(refuse), .count_o(count)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_x_q   <= res_x;
      out_y_q   <= res_y;
      out_z_q   <= res_z;
      refused_q <= refuse;
      total_q   <= count;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.out_x         = out_x_q;
  assign result_o.out_y         = out_y_q;
  assign result_o.out_z         = out_z_q;
  assign result_o.refused       = refused_q;
  assign result_o.refused_total = total_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SQ))
    else $error("accepted word did not start the sequence");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out |=> out_valid_q))
    else $error("finished word not held at output");

  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count >= $past(count)) && (count - $past(count) <= 1))
    else $error("refusal count stepped wrong");

  a_refuse_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_BOB) && refuse && (count != '1)) |=> (count == $past(count) + 1'b1))
    else $error("refused word not counted");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = gers_pkg::COORD_WIDTH_DEF;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;
  localparam int WALK_ITEMS = 125;
  localparam int PHASES = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 8;
  localparam int DRAIN = 20;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 restart;
  } sample_t;

  typedef struct packed {
    logic signed [CW-1:0]       x;
    logic signed [CW-1:0]       y;
    logic signed [CW-1:0]       z;
    logic                       refused;
    logic [gers_pkg::CNT_W-1:0] total;
  } point_out_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    sample_t     pt;
    logic        typed;
    point_out_t  want;
  } step_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [gers_pkg::PADDR_W-1:0] paddr;
  logic [gers_pkg::PDATA_W-1:0] pwdata;
  logic [gers_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  gers_in_if  #(.COORD_WIDTH(CW)) smp ();
  gers_out_if #(.COORD_WIDTH(CW)) res ();

  gated_ema_residual_scaler_3d_top #(.COORD_WIDTH(CW)) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp),
    .result_o (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // predicted block state
  logic [gers_pkg::BOB_W-1:0]  bob_q  = gers_pkg::BOB_RST;
  logic [gers_pkg::DAMP_W-1:0] damp_q = gers_pkg::DAMP_RST;
  logic [gers_pkg::JUMP_W-1:0] jump_q = gers_pkg::JUMP_RST;
  longint                      mean_pt [3] = '{0, 0, 0};
  bit                          mean_ok = 1'b0;
  logic [gers_pkg::CNT_W-1:0]  refusals = '0;

  point_out_t pending_points [$];
  longint     walk_base [3] = '{0, 0, 0};

  bit idle_on  = 1'b0;
  bit hold_req = 1'b0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_refused = 0;
  int n_restart = 0;
  int n_writes = 0;
  int n_settings = 1;

  function automatic longint round_q16(longint p);
    return (p + gers_pkg::COEF_HALF) >>> gers_pkg::COEF_BITS;
  endfunction

  function automatic longint sat_coord(longint v);
    return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
  endfunction

  function automatic longint rand_off(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [31:0] val);
    logic [gers_pkg::BOB_W-1:0]  b;
    logic [gers_pkg::DAMP_W-1:0] dm;
    logic [gers_pkg::JUMP_W-1:0] j;
    b  = val[gers_pkg::BOB_W-1:0];
    dm = val[gers_pkg::DAMP_W-1:0];
    j  = val[gers_pkg::JUMP_W-1:0];
    case (idx)
      gers_pkg::REG_BOB:  bob_q  = (b > gers_pkg::BOB_MAX) ? gers_pkg::BOB_MAX : b;
      gers_pkg::REG_DAMP: damp_q = (dm > gers_pkg::DAMP_MAX) ? gers_pkg::DAMP_MAX : dm;
      gers_pkg::REG_JUMP: jump_q = (j < gers_pkg::JUMP_MIN) ? gers_pkg::JUMP_MIN :
                                   ((j > gers_pkg::JUMP_MAX) ? gers_pkg::JUMP_MAX : j);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(logic [1:0] idx);
    case (idx)
      gers_pkg::REG_BOB:  return 32'(bob_q);
      gers_pkg::REG_DAMP: return 32'(damp_q);
      default:            return 32'(jump_q);
    endcase
  endfunction

  function automatic point_out_t ema_step(sample_t s);
    longint     raw [3];
    longint     d [3];
    longint     ov [3];
    longint     m;
    longint     r;
    longint     mj;
    longint     w;
    longint     dist2;
    bit         refuse;
    point_out_t o;
    raw[0] = s.x;
    raw[1] = s.y;
    raw[2] = s.z;
    if (s.restart || !mean_ok) begin
      for (int i = 0; i < 3; i++) mean_pt[i] = raw[i];
      mean_ok = 1'b1;
    end
    mj = longint'(jump_q);
    refuse = 1'b0;
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = raw[i] - mean_pt[i];
      if (((d[i] < 0) ? -d[i] : d[i]) > mj) refuse = 1'b1;
      dist2 += d[i] * d[i];
    end
    if (dist2 > mj * mj) refuse = 1'b1;
    if (refuse) begin
      if (refusals != '1) refusals++;
      for (int i = 0; i < 3; i++) ov[i] = mean_pt[i];
    end else begin
      w = longint'(gers_pkg::COEF_ONE) - longint'(damp_q);
      for (int i = 0; i < 3; i++) begin
        m = mean_pt[i] + round_q16(w * d[i]);
        r = raw[i] - m;
        mean_pt[i] = m;
        ov[i] = m + round_q16(longint'(bob_q) * r);
      end
    end
    o.x = CW'(ov[0]);
    o.y = CW'(ov[1]);
    o.z = CW'(ov[2]);
    o.refused = refuse;
    o.total = refusals;
    return o;
  endfunction

  function automatic sample_t walk_sample();
    sample_t s;
    longint  span;
    longint  pv [3];
    int      kind;
    kind = $urandom_range(0, 99);
    span = longint'(jump_q);
    s.restart = 1'b0;
    if (kind < 8) begin
      // noise over the full field range
      s.x = CW'($urandom);
      s.y = CW'($urandom);
      s.z = CW'($urandom);
      s.restart = 1'($urandom_range(0, 1));
    end else begin
      if (kind < 14) begin
        for (int i = 0; i < 3; i++) walk_base[i] = sat_coord(rand_off(CMAX));
        s.restart = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) walk_base[i] = sat_coord(walk_base[i] + rand_off(span / 8));
      end
      for (int i = 0; i < 3; i++) begin
        if (kind < 14) pv[i] = walk_base[i];
        else if (kind < 22) pv[i] = sat_coord(walk_base[i] + rand_off(4 * span));
        else pv[i] = sat_coord(walk_base[i] + rand_off(span / 2));
      end
      s.x = CW'(pv[0]);
      s.y = CW'(pv[1]);
      s.z = CW'(pv[2]);
    end
    return s;
  endfunction

  function automatic logic [31:0] pick_reg_val(logic [1:0] idx, int mode);
    if (mode == 3) return $urandom;
    case (idx)
      gers_pkg::REG_BOB: begin
        if (mode == 0) return 32'd0;
        if (mode == 1) return 32'(gers_pkg::BOB_MAX);
        return $urandom_range(0, gers_pkg::BOB_MAX);
      end
      gers_pkg::REG_DAMP: begin
        if (mode == 0) return 32'd0;
        if (mode == 1) return 32'(gers_pkg::DAMP_MAX);
        return $urandom_range(0, gers_pkg::DAMP_MAX);
      end
      default: begin
        if (mode == 0) return 32'(gers_pkg::JUMP_MIN);
        if (mode == 1) return 32'(gers_pkg::JUMP_MAX);
        return $urandom_range(gers_pkg::JUMP_MIN, gers_pkg::JUMP_MAX);
      end
    endcase
  endfunction

  function automatic int mode_for(int ph);
    if (ph == 0) return 2;
    if (ph == 1) return 0;
    if (ph == 2) return 1;
    return $urandom_range(0, 3);
  endfunction

  function automatic step_row_t sample_row(int x, int y, int z, bit rs);
    step_row_t row;
    row = '0;
    row.kind = ROW_SAMPLE;
    row.pt.x = CW'(x);
    row.pt.y = CW'(y);
    row.pt.z = CW'(z);
    row.pt.restart = rs;
    return row;
  endfunction

  function automatic step_row_t typed_row(int x, int y, int z, bit rs,
                                          int ox, int oy, int oz, bit rf, int unsigned tot);
    step_row_t row;
    row = sample_row(x, y, z, rs);
    row.typed = 1'b1;
    row.want.x = CW'(ox);
    row.want.y = CW'(oy);
    row.want.z = CW'(oz);
    row.want.refused = rf;
    row.want.total = tot;
    return row;
  endfunction

  function automatic step_row_t write_row(logic [1:0] idx, logic [31:0] val);
    step_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic note_mismatch(string field, longint want, longint got);
    $display("tb_top: word %0d %s expected %0d got %0d", n_checked, field, want, got);
    errors++;
  endtask

  task automatic offer(sample_t s, logic typed, point_out_t want);
    int         gap;
    point_out_t calc;
    smp.valid   <= 1'b1;
    smp.raw_x   <= s.x;
    smp.raw_y   <= s.y;
    smp.raw_z   <= s.z;
    smp.restart <= s.restart;
    do @(posedge clk_i); while (!smp.ready);
    calc = ema_step(s);
    pending_points.push_back(typed ? want : calc);
    n_sent++;
    if (s.restart) n_restart++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    smp.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    apply_reg(idx, val);
    n_writes++;
    if (idx == REG_SPARE) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      // read back through the same port
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      if (prdata !== reg_value(idx)) note_mismatch("prdata", reg_value(idx), prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    @(posedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    int gap;
    int hold_left;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk_i);
          hold_left--;
        end
        res.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        gap = $urandom_range(1, 16);
        repeat (gap) @(posedge clk_i);
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_word
    point_out_t want_w;
    if (rst_ni && res.valid && res.ready) begin
      n_checked++;
      if (res.refused === 1'b1) n_refused++;
      if (pending_points.size() == 0) begin
        note_mismatch("unexpected word", 0, 0);
      end else begin
        want_w = pending_points.pop_front();
        if (res.out_x !== want_w.x) note_mismatch("out_x", want_w.x, res.out_x);
        if (res.out_y !== want_w.y) note_mismatch("out_y", want_w.y, res.out_y);
        if (res.out_z !== want_w.z) note_mismatch("out_z", want_w.z, res.out_z);
        if (res.refused !== want_w.refused) note_mismatch("refused", want_w.refused, res.refused);
        if (res.refused_total !== want_w.total) begin
          note_mismatch("refused_total", want_w.total, res.refused_total);
        end
      end
    end
  end

  initial begin
    step_row_t rows [$];
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    smp.valid   = 1'b0;
    smp.raw_x   = '0;
    smp.raw_y   = '0;
    smp.raw_z   = '0;
    smp.restart = 1'b0;

    // defaults after reset: first word seeds, refusals by axis and by sum of squares
    rows.push_back(typed_row(8388607, -8388608, 0, 0, 8388607, -8388608, 0, 0, 0));
    rows.push_back(typed_row(8388607, -8388608, 0, 0, 8388607, -8388608, 0, 0, 0));
    rows.push_back(typed_row(-8388608, -8388608, 0, 0, 8388607, -8388608, 0, 1, 1));
    rows.push_back(typed_row(0, 0, 0, 1, 0, 0, 0, 0, 1));
    rows.push_back(sample_row(32768, 0, 0, 0));
    rows.push_back(typed_row(37684, 0, 0, 0, 4915, 0, 0, 1, 2));
    rows.push_back(typed_row(24915, 20000, 20000, 0, 4915, 0, 0, 1, 3));
    rows.push_back(sample_row(-5085, -10000, -10000, 0));
    // out of range writes clamp, spare address is ignored
    rows.push_back(write_row(gers_pkg::REG_BOB, 32'h0001_FFFF));
    rows.push_back(write_row(gers_pkg::REG_DAMP, 32'h0000_FFFF));
    rows.push_back(write_row(gers_pkg::REG_JUMP, 32'h0000_0000));
    rows.push_back(write_row(REG_SPARE, 32'hFFFF_FFFF));
    rows.push_back(typed_row(100, -100, 50, 1, 100, -100, 50, 0, 3));
    rows.push_back(typed_row(3377, -100, 50, 0, 3377, -100, 50, 0, 3));
    rows.push_back(write_row(gers_pkg::REG_BOB, 32'd0));
    rows.push_back(write_row(gers_pkg::REG_DAMP, 32'd0));
    rows.push_back(write_row(gers_pkg::REG_JUMP, 32'hFFFF_FFFF));
    rows.push_back(typed_row(-8388608, 8388607, -8388608, 1,
                             -8388608, 8388607, -8388608, 0, 3));
    rows.push_back(typed_row(-8060928, 8388607, -8388608, 0,
                             -8060928, 8388607, -8388608, 0, 3));
    rows.push_back(typed_row(8388607, 8388607, 8388607, 0,
                             -8060928, 8388607, -8388608, 1, 4));
    rows.push_back(write_row(gers_pkg::REG_BOB, 32'd16384));
    rows.push_back(write_row(gers_pkg::REG_DAMP, 32'd32768));
    rows.push_back(write_row(gers_pkg::REG_JUMP, 32'd65536));
    rows.push_back(typed_row(0, 0, 0, 1, 0, 0, 0, 0, 4));
    rows.push_back(sample_row(-1, 1, 65535, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_WRITE) begin
        settle();
        cfg_write(rows[k].reg_idx, rows[k].reg_val);
        n_settings++;
      end else begin
        offer(rows[k].pt, rows[k].typed, rows[k].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      cfg_write(gers_pkg::REG_BOB, pick_reg_val(gers_pkg::REG_BOB, mode_for(ph)));
      cfg_write(gers_pkg::REG_DAMP, pick_reg_val(gers_pkg::REG_DAMP, mode_for(ph)));
      cfg_write(gers_pkg::REG_JUMP, pick_reg_val(gers_pkg::REG_JUMP, mode_for(ph)));
      n_settings++;
      idle_on = (ph != 2) && (ph != PHASES - 1);
      if (ph == 3) hold_req = 1'b1;
      repeat (WALK_ITEMS) offer(walk_sample(), 1'b0, '0);
    end

    settle();
    repeat (DRAIN) @(posedge clk_i);
    $display("tb_top: %0d samples sent, %0d results checked, %0d refused, %0d restarts",
             n_sent, n_checked, n_refused, n_restart);
    $display("tb_top: %0d register writes over %0d settings, one %0d cycle output hold",
             n_writes, n_settings, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
